>>> sv/ttlcpu_pkg.sv
package ttlcpu_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned PC_W   = 16;

    localparam logic [2:0] OP_LD  = 3'd0;
    localparam logic [2:0] OP_AND = 3'd1;
    localparam logic [2:0] OP_OR  = 3'd2;
    localparam logic [2:0] OP_XOR = 3'd3;
    localparam logic [2:0] OP_ADD = 3'd4;
    localparam logic [2:0] OP_SUB = 3'd5;
    localparam logic [2:0] OP_ST  = 3'd6;
    localparam logic [2:0] OP_JMP = 3'd7;

    localparam logic [2:0] MODE_D_AC   = 3'd0;
    localparam logic [2:0] MODE_X_AC   = 3'd1;
    localparam logic [2:0] MODE_YD_AC  = 3'd2;
    localparam logic [2:0] MODE_YX_AC  = 3'd3;
    localparam logic [2:0] MODE_D_X    = 3'd4;
    localparam logic [2:0] MODE_D_Y    = 3'd5;
    localparam logic [2:0] MODE_D_OUT  = 3'd6;
    localparam logic [2:0] MODE_YXI_OUT = 3'd7;

    localparam logic [2:0] MODE_FAR = 3'd0;

    localparam logic [1:0] BUS_D   = 2'd0;
    localparam logic [1:0] BUS_RAM = 2'd1;
    localparam logic [1:0] BUS_AC  = 2'd2;
    localparam logic [1:0] BUS_IN  = 2'd3;

    localparam logic [1:0] COND_GT = 2'd0;
    localparam logic [1:0] COND_LT = 2'd1;
    localparam logic [1:0] COND_EQ = 2'd2;

    localparam logic [PC_W-1:0] PAGE_MASK = 16'hff00;

    typedef struct packed {
        logic [2:0] op;
        logic [2:0] mode;
        logic [1:0] bsel;
    } instr_t;

endpackage

>>> sv/eight_bit_ttl_cpu_cycle_unit.sv
// Channel | Dir | tdata fields (lowest bit up)
// s_axis  | in  | rom_instr[7:0], rom_data[15:8], in_port[23:16], float_bus[31:24]
// m_axis  | out | fetch_pc[15:0], out_reg[23:16], acc[31:24], x_reg[39:32], y_reg[47:40]
//
// One item per cycle unless the output stalls; the result is valid the cycle after accept.
// The RAM operand for the next item is read when the current item is accepted;
// a store to the same entry in that cycle is forwarded.
// Reset clears PC, IR, D, AC, X, Y and OUT; the data RAM is not cleared.
// A stalled result holds the registers and the RAM read; s_tready follows
// the free output slot.
module eight_bit_ttl_cpu_cycle_unit #(
    parameter int unsigned RAM_ADDR_BITS = 15
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // rom_instr, rom_data, in_port, float_bus
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // fetch_pc, out_reg, acc, x_reg, y_reg
);
    import ttlcpu_pkg::*;

    localparam int unsigned RAM_DEPTH = 1 << RAM_ADDR_BITS;

    logic [PC_W-1:0]   pc_reg;
    logic [BYTE_W-1:0] ir_reg;
    logic [BYTE_W-1:0] d_reg;
    logic [BYTE_W-1:0] ac_reg;
    logic [BYTE_W-1:0] x_reg;
    logic [BYTE_W-1:0] y_reg;
    logic [BYTE_W-1:0] out_reg;
    logic              m_valid_reg;
    logic              fwd_reg;
    logic [BYTE_W-1:0] fwd_data_reg;
    logic [BYTE_W-1:0] ram_q_reg;

    logic [BYTE_W-1:0] ram [RAM_DEPTH];

    instr_t            ir;
    logic              accept;
    logic              is_store;
    logic              is_jump;
    logic [BYTE_W-1:0] in_ir;
    logic [BYTE_W-1:0] in_d;
    logic [BYTE_W-1:0] in_port;
    logic [BYTE_W-1:0] float_bus;
    logic [RAM_ADDR_BITS-1:0] wr_addr;
    logic [RAM_ADDR_BITS-1:0] rd_addr;
    logic [BYTE_W-1:0] ram_rd;
    logic [BYTE_W-1:0] bus;
    logic [BYTE_W-1:0] alu;
    logic [1:0]        cond;
    logic [PC_W-1:0]   pc_next;
    logic [BYTE_W-1:0] ac_next;
    logic [BYTE_W-1:0] x_next;
    logic [BYTE_W-1:0] y_next;
    logic [BYTE_W-1:0] out_next;

    function automatic logic [RAM_ADDR_BITS-1:0] addr_f(
        input logic [BYTE_W-1:0] instr,
        input logic [BYTE_W-1:0] d,
        input logic [BYTE_W-1:0] x,
        input logic [BYTE_W-1:0] y
    );
        instr_t            i;
        logic [BYTE_W-1:0] lo;
        logic [BYTE_W-1:0] hi;
        logic [PC_W-1:0]   full;
        i  = instr_t'(instr);
        lo = d;
        hi = '0;
        if (i.op != OP_JMP)
        begin
            unique case (i.mode)
                MODE_X_AC:
                begin
                    lo = x;
                end
                MODE_YD_AC:
                begin
                    hi = y;
                end
                MODE_YX_AC, MODE_YXI_OUT:
                begin
                    lo = x;
                    hi = y;
                end
                default:
                begin
                    lo = d;
                end
            endcase
        end
        full = {hi, lo};
        return full[RAM_ADDR_BITS-1:0];
    endfunction

    assign in_ir     = s_tdata[7:0];
    assign in_d      = s_tdata[15:8];
    assign in_port   = s_tdata[23:16];
    assign float_bus = s_tdata[31:24];

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {y_reg, x_reg, ac_reg, out_reg, pc_reg};

    assign ir       = instr_t'(ir_reg);
    assign is_store = (ir.op == OP_ST);
    assign is_jump  = (ir.op == OP_JMP);
    assign wr_addr  = addr_f(ir_reg, d_reg, x_reg, y_reg);
    assign ram_rd   = fwd_reg ? fwd_data_reg : ram_q_reg;

    always_comb
    begin
        unique case (ir.bsel)
            BUS_D:   bus = d_reg;
            BUS_RAM: bus = is_store ? float_bus : ram_rd;
            BUS_AC:  bus = ac_reg;
            BUS_IN:  bus = in_port;
            default: bus = d_reg;
        endcase
    end

    always_comb
    begin
        unique case (ir.op)
            OP_LD:   alu = bus;
            OP_AND:  alu = ac_reg & bus;
            OP_OR:   alu = ac_reg | bus;
            OP_XOR:  alu = ac_reg ^ bus;
            OP_ADD:  alu = ac_reg + bus;
            OP_SUB:  alu = ac_reg - bus;
            OP_ST:   alu = ac_reg;
            OP_JMP:  alu = 8'd0 - ac_reg;
            default: alu = bus;
        endcase
    end

    always_comb
    begin
        ac_next  = ac_reg;
        x_next   = x_reg;
        y_next   = y_reg;
        out_next = out_reg;
        if (!is_jump)
        begin
            unique case (ir.mode)
                MODE_D_AC, MODE_X_AC, MODE_YD_AC, MODE_YX_AC:
                begin
                    if (!is_store)
                    begin
                        ac_next = alu;
                    end
                end
                MODE_D_X:
                begin
                    x_next = alu;
                end
                MODE_D_Y:
                begin
                    y_next = alu;
                end
                MODE_D_OUT:
                begin
                    if (!is_store)
                    begin
                        out_next = alu;
                    end
                end
                MODE_YXI_OUT:
                begin
                    if (!is_store)
                    begin
                        out_next = alu;
                    end
                    x_next = x_reg + 8'd1;
                end
                default:
                begin
                    ac_next = ac_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        if (ac_reg == '0)
        begin
            cond = COND_EQ;
        end
        else if (ac_reg[7])
        begin
            cond = COND_LT;
        end
        else
        begin
            cond = COND_GT;
        end
        pc_next = pc_reg + 16'd1;
        if (is_jump)
        begin
            if (ir.mode == MODE_FAR)
            begin
                pc_next = {y_reg, bus};
            end
            else if (ir.mode[cond])
            begin
                pc_next = (pc_reg & PAGE_MASK) | {8'd0, bus};
            end
        end
    end

    assign rd_addr = addr_f(in_ir, in_d, x_next, y_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg      <= '0;
            ir_reg      <= '0;
            d_reg       <= '0;
            ac_reg      <= '0;
            x_reg       <= '0;
            y_reg       <= '0;
            out_reg     <= '0;
            m_valid_reg <= 1'b0;
            fwd_reg     <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                pc_reg  <= pc_next;
                ir_reg  <= in_ir;
                d_reg   <= in_d;
                ac_reg  <= ac_next;
                x_reg   <= x_next;
                y_reg   <= y_next;
                out_reg <= out_next;
                fwd_reg <= is_store && (wr_addr == rd_addr);
            end
            if (accept)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fwd_data_reg <= bus;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && is_store)
        begin
            ram[wr_addr] <= bus;
        end
        if (accept)
        begin
            ram_q_reg <= ram[rd_addr];
        end
    end

endmodule

>>> sv/ttlcpu_check.sv
module ttlcpu_check (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted item gave no result");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !(s_tvalid && s_tready) |=> !m_tvalid)
        else $error("result repeated");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    a_still: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tvalid && s_tready) && m_tvalid |=> $stable(m_tdata))
        else $error("state moved without an item");

endmodule

bind eight_bit_ttl_cpu_cycle_unit ttlcpu_check u_ttlcpu_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> tb/cpu_cycle_checker.sv
`timescale 1ns / 1ps

module cpu_cycle_checker
    import ttlcpu_pkg::*;
#(
    parameter int unsigned RAM_ADDR_BITS = 15
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,   // rom_instr, rom_data, in_port, float_bus
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,   // fetch_pc, out_reg, acc, x_reg, y_reg
    output int          errors,
    output int          outstanding
);

    typedef enum logic [2:0] {DST_NONE, DST_AC, DST_X, DST_Y, DST_OUT} dst_t;

    logic [PC_W-1:0]   pc;
    logic [BYTE_W-1:0] ir;
    logic [BYTE_W-1:0] dr;
    logic [BYTE_W-1:0] ac;
    logic [BYTE_W-1:0] xr;
    logic [BYTE_W-1:0] yr;
    logic [BYTE_W-1:0] outl;
    logic [BYTE_W-1:0] ram [0:(1 << RAM_ADDR_BITS)-1];

    logic [47:0] regs_due_q [$];
    logic [47:0] regs_want;
    int          fails;

    task automatic step_cpu(input logic [31:0] item, output logic [47:0] regs);
        instr_t                   cur;
        logic                     st;
        logic                     jmp;
        logic [BYTE_W-1:0]        lo;
        logic [BYTE_W-1:0]        hi;
        logic [15:0]              full;
        logic [RAM_ADDR_BITS-1:0] addr;
        logic [BYTE_W-1:0]        bus;
        logic [BYTE_W-1:0]        alu;
        logic [BYTE_W-1:0]        nac;
        logic [BYTE_W-1:0]        nx;
        logic [BYTE_W-1:0]        ny;
        logic [BYTE_W-1:0]        nout;
        logic [PC_W-1:0]          npc;
        logic [1:0]               cond;
        logic                     incx;
        dst_t                     dst;
        begin
            cur  = ir;
            st   = (cur.op == OP_ST);
            jmp  = (cur.op == OP_JMP);
            lo   = dr;
            hi   = '0;
            dst  = DST_NONE;
            incx = 1'b0;
            if (!jmp)
            begin
                case (cur.mode)
                    MODE_D_AC:  dst = DST_AC;
                    MODE_X_AC:
                    begin
                        dst = DST_AC;
                        lo  = xr;
                    end
                    MODE_YD_AC:
                    begin
                        dst = DST_AC;
                        hi  = yr;
                    end
                    MODE_YX_AC:
                    begin
                        dst = DST_AC;
                        lo  = xr;
                        hi  = yr;
                    end
                    MODE_D_X:   dst = DST_X;
                    MODE_D_Y:   dst = DST_Y;
                    MODE_D_OUT: dst = DST_OUT;
                    default:
                    begin
                        dst  = DST_OUT;
                        lo   = xr;
                        hi   = yr;
                        incx = 1'b1;
                    end
                endcase
                if (st && (dst == DST_AC || dst == DST_OUT))
                    dst = DST_NONE;
            end
            full = {hi, lo};
            addr = full[RAM_ADDR_BITS-1:0];

            case (cur.bsel)
                BUS_D:   bus = dr;
                BUS_RAM: bus = st ? item[31:24] : ram[addr];
                BUS_AC:  bus = ac;
                default: bus = item[23:16];
            endcase
            if (st)
                ram[addr] = bus;

            case (cur.op)
                OP_LD:   alu = bus;
                OP_AND:  alu = ac & bus;
                OP_OR:   alu = ac | bus;
                OP_XOR:  alu = ac ^ bus;
                OP_ADD:  alu = ac + bus;
                OP_SUB:  alu = ac - bus;
                OP_ST:   alu = ac;
                default: alu = 8'h00 - ac;
            endcase

            nac  = ac;
            nx   = xr;
            ny   = yr;
            nout = outl;
            case (dst)
                DST_AC:  nac  = alu;
                DST_X:   nx   = alu;
                DST_Y:   ny   = alu;
                DST_OUT: nout = alu;
                default: ;
            endcase
            if (incx)
                nx = xr + 8'd1;

            npc = pc + 16'd1;
            if (jmp)
            begin
                if (cur.mode == MODE_FAR)
                    npc = {yr, bus};
                else
                begin
                    cond = (ac == 8'h00) ? COND_EQ : (ac[7] ? COND_LT : COND_GT);
                    if (cur.mode[cond])
                        npc = (pc & PAGE_MASK) | {8'h00, bus};
                end
            end

            pc   = npc;
            ir   = item[7:0];
            dr   = item[15:8];
            ac   = nac;
            xr   = nx;
            yr   = ny;
            outl = nout;
            regs = {ny, nx, nac, nout, npc};
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
        if (got !== want)
        begin
            fails++;
            if (fails <= 10)
                $display("chk: %0t %s expected %h got %h", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc    = '0;
            ir    = '0;
            dr    = '0;
            ac    = '0;
            xr    = '0;
            yr    = '0;
            outl  = '0;
            fails = 0;
            regs_due_q.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (regs_due_q.size() == 0)
                begin
                    fails++;
                    if (fails <= 10)
                        $display("chk: %0t result %h with none pending", $time, m_tdata);
                end
                else
                begin
                    regs_want = regs_due_q.pop_front();
                    check_field("fetch_pc", regs_want[15:0], m_tdata[15:0]);
                    check_field("out_reg", regs_want[23:16], m_tdata[23:16]);
                    check_field("acc", regs_want[31:24], m_tdata[31:24]);
                    check_field("x_reg", regs_want[39:32], m_tdata[39:32]);
                    check_field("y_reg", regs_want[47:40], m_tdata[47:40]);
                end
            end
            if (s_tvalid && s_tready)
            begin
                step_cpu(s_tdata, regs_want);
                regs_due_q.push_back(regs_want);
            end
        end
        errors      <= fails;
        outstanding <= regs_due_q.size();
    end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import ttlcpu_pkg::*;

    localparam int unsigned RAM_BITS     = 15;
    localparam int          RANDOM_ITEMS = 550;

    localparam logic [2:0] JMP_IF_GT  = 3'(1 << COND_GT);
    localparam logic [2:0] JMP_IF_LT  = 3'(1 << COND_LT);
    localparam logic [2:0] JMP_IF_EQ  = 3'(1 << COND_EQ);
    localparam logic [2:0] JMP_ALWAYS = JMP_IF_GT | JMP_IF_LT | JMP_IF_EQ;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [31:0] s_tdata  = '0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [47:0] m_tdata;

    int errors;
    int outstanding;
    int items_sent   = 0;
    int results_seen = 0;
    int idle_pct     = 0;
    int stall_pct    = 0;

    // where X and Y stand when the next fetched instruction executes
    bit          x_known  = 1'b1;
    bit          y_known  = 1'b1;
    logic [7:0]  x_shadow = '0;
    logic [7:0]  y_shadow = '0;
    bit          ram_filled [0:(1 << RAM_BITS)-1];
    logic [7:0]  byte_pool [0:7] = '{8'h00, 8'h01, 8'h02, 8'h03, 8'h7f, 8'h80, 8'hfe, 8'hff};

    // instruction held in the block; it executes with the next item's port bytes
    instr_t      last_c   = '0;
    logic [7:0]  last_d   = '0;

    eight_bit_ttl_cpu_cycle_unit #(
        .RAM_ADDR_BITS(RAM_BITS)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    cpu_cycle_checker #(
        .RAM_ADDR_BITS(RAM_BITS)
    ) i_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .errors      (errors),
        .outstanding (outstanding)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("tb: done, errors");
        $finish;
    end

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
        if (m_tvalid && m_tready)
            results_seen <= results_seen + 1;

    function automatic instr_t enc(logic [2:0] op, logic [2:0] md, logic [1:0] bs);
        return {op, md, bs};
    endfunction

    function automatic logic [7:0] pick_byte();
        if ($urandom_range(1))
            return byte_pool[$urandom_range(7)];
        return 8'($urandom_range(255));
    endfunction

    function automatic bit locate(instr_t c, logic [7:0] d, output logic [RAM_BITS-1:0] addr);
        logic [15:0] full;
        bit          ok;
        begin
            full = {8'h00, d};
            ok   = 1'b1;
            if (c.op != OP_JMP)
            begin
                case (c.mode)
                    MODE_X_AC:
                    begin
                        full = {8'h00, x_shadow};
                        ok   = x_known;
                    end
                    MODE_YD_AC:
                    begin
                        full = {y_shadow, d};
                        ok   = y_known;
                    end
                    MODE_YX_AC, MODE_YXI_OUT:
                    begin
                        full = {y_shadow, x_shadow};
                        ok   = x_known && y_known;
                    end
                    default: ;
                endcase
            end
            addr = full[RAM_BITS-1:0];
            return ok;
        end
    endfunction

    function automatic bit read_ok(instr_t c, logic [7:0] d);
        logic [RAM_BITS-1:0] addr;
        begin
            if (c.bsel != BUS_RAM || c.op == OP_ST)
                return 1'b1;
            return locate(c, d, addr) && ram_filled[addr];
        end
    endfunction

    task automatic track_item(input instr_t c, input logic [7:0] d, input logic [7:0] pin);
        logic [RAM_BITS-1:0] addr;
        bit                  from_bus;
        begin
            if (c.op == OP_JMP)
                return;
            if (c.op == OP_ST && locate(c, d, addr))
                ram_filled[addr] = 1'b1;
            from_bus = (c.op == OP_LD) && (c.bsel == BUS_D || c.bsel == BUS_IN);
            case (c.mode)
                MODE_D_X:
                begin
                    x_known  = from_bus;
                    x_shadow = (c.bsel == BUS_D) ? d : pin;
                end
                MODE_D_Y:
                begin
                    y_known  = from_bus;
                    y_shadow = (c.bsel == BUS_D) ? d : pin;
                end
                MODE_YXI_OUT: x_shadow = x_shadow + 8'd1;
                default: ;
            endcase
        end
    endtask

    task automatic send_item(input instr_t c, input logic [7:0] d, input logic [7:0] pin,
                             input logic [7:0] fl);
        begin
            track_item(last_c, last_d, pin);
            if (!read_ok(c, d))
                c.bsel = BUS_D;
            last_c = c;
            last_d = d;
            while ($urandom_range(99) < idle_pct)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= {fl, pin, d, c};
            do
                @(posedge clk);
            while (!s_tready);
            items_sent++;
        end
    endtask

    task automatic random_item();
        instr_t     c;
        logic [7:0] d;
        int         tries;
        begin
            c.op   = ($urandom_range(99) < 25) ? OP_LD : 3'($urandom_range(7));
            c.mode = 3'($urandom_range(7));
            c.bsel = 2'($urandom_range(3));
            if ((!x_known || !y_known) && $urandom_range(3) == 0)
            begin
                c.op   = OP_LD;
                c.mode = !x_known ? MODE_D_X : MODE_D_Y;
                c.bsel = $urandom_range(1) ? BUS_D : BUS_IN;
            end
            d = pick_byte();
            for (tries = 0; tries < 12 && !read_ok(c, d); tries++)
                d = pick_byte();
            send_item(c, d, pick_byte(), 8'($urandom_range(255)));
        end
    endtask

    task automatic directed_items();
        begin
            send_item(enc(OP_LD,  MODE_D_AC,    BUS_D),   8'h00, pick_byte(), pick_byte());
            send_item(enc(OP_JMP, JMP_IF_GT,    BUS_D),   8'h40, pick_byte(), pick_byte());
            send_item(enc(OP_JMP, JMP_IF_EQ,    BUS_D),   8'h20, pick_byte(), pick_byte());
            send_item(enc(OP_LD,  MODE_D_AC,    BUS_D),   8'h80, pick_byte(), pick_byte());
            send_item(enc(OP_JMP, JMP_IF_LT,    BUS_AC),  8'h11, pick_byte(), pick_byte());
            send_item(enc(OP_LD,  MODE_D_Y,     BUS_D),   8'hff, pick_byte(), pick_byte());
            // far jump to the top of the code space, then the PC wraps
            send_item(enc(OP_JMP, MODE_FAR,     BUS_D),   8'hff, pick_byte(), pick_byte());
            send_item(enc(OP_LD,  MODE_D_X,     BUS_IN),  8'h33, pick_byte(), pick_byte());
            send_item(enc(OP_ST,  MODE_YXI_OUT, BUS_AC),  8'h00, 8'hff,       pick_byte());
            send_item(enc(OP_LD,  MODE_D_X,     BUS_D),   8'hff, pick_byte(), pick_byte());
            send_item(enc(OP_LD,  MODE_YX_AC,   BUS_RAM), 8'h00, pick_byte(), pick_byte());
            send_item(enc(OP_ST,  MODE_D_AC,    BUS_RAM), 8'h00, pick_byte(), pick_byte());
            send_item(enc(OP_ADD, MODE_D_AC,    BUS_RAM), 8'h00, pick_byte(), 8'h5a);
            send_item(enc(OP_SUB, MODE_D_AC,    BUS_D),   8'hff, pick_byte(), pick_byte());
            send_item(enc(OP_AND, MODE_X_AC,    BUS_AC),  8'h00, pick_byte(), pick_byte());
            send_item(enc(OP_OR,  MODE_YD_AC,   BUS_IN),  8'h00, pick_byte(), pick_byte());
            send_item(enc(OP_XOR, MODE_D_AC,    BUS_D),   8'hff, 8'h81,       pick_byte());
            send_item(enc(OP_ST,  MODE_D_X,     BUS_D),   8'h01, pick_byte(), pick_byte());
            send_item(enc(OP_ST,  MODE_D_Y,     BUS_IN),  8'h02, pick_byte(), pick_byte());
            send_item(enc(OP_LD,  MODE_D_OUT,   BUS_RAM), 8'h01, 8'h7e,       pick_byte());
            send_item(enc(OP_JMP, JMP_ALWAYS,   BUS_RAM), 8'h02, pick_byte(), pick_byte());
            // Y bit 7 falls outside the RAM address
            send_item(enc(OP_LD,  MODE_D_Y,     BUS_D),   8'h80, pick_byte(), pick_byte());
            send_item(enc(OP_LD,  MODE_D_X,     BUS_D),   8'h00, pick_byte(), pick_byte());
            send_item(enc(OP_LD,  MODE_YX_AC,   BUS_RAM), 8'h00, pick_byte(), pick_byte());
            send_item(enc(OP_LD,  MODE_X_AC,    BUS_RAM), 8'h00, pick_byte(), pick_byte());
        end
    endtask

    initial
    begin : stim
        int ph;
        int n_directed;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_items();
        n_directed = items_sent;
        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    idle_pct = 0;
                    stall_pct <= 0;
                end
                1:
                begin
                    idle_pct = 59;
                    stall_pct <= 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct <= 59;
                end
                default:
                begin
                    idle_pct = 6;
                    stall_pct <= 6;
                end
            endcase
            repeat (RANDOM_ITEMS / 4) random_item();
            s_tvalid <= 1'b0;
            while (results_seen != items_sent)
                @(posedge clk);
        end
        repeat (8) @(posedge clk);
        $display("tb: %0d items (%0d directed) sent, %0d results checked", items_sent,
                 n_directed, results_seen);
        $display("tb: handshake phases: free run, sparse input, stalled output, light mix");
        if (errors == 0 && outstanding == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

>>> filelist.f
sv/ttlcpu_pkg.sv
sv/eight_bit_ttl_cpu_cycle_unit.sv
sv/ttlcpu_check.sv
tb/cpu_cycle_checker.sv
tb/tb.sv
